>>> sv/tkf_pkg.sv
// Shared types and constants for the top-k frequent stream core.
// Holds the controller-to-datapath command and status structs.
// No dependencies.
package tkf_pkg;

  // Width of a stream value and of the configuration word.
  localparam int VALUE_BITS = 10;
  localparam int CFG_BITS   = 5;

  // Value of top_count after reset.
  localparam logic [CFG_BITS-1:0] TOP_COUNT_RESET = 5'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;        // write zero at the clearing address and advance it
    logic load;       // capture the accepted request
    logic read;       // read the count of the captured value
    logic bump;       // write back the saturated incremented count
    logic rank;       // compare the value against every list entry
    logic update;     // apply removal, insertion and truncation to the list
    logic emit_step;  // advance to the next list entry being reported
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;   // clearing address is at the last table entry
    logic emit_last;  // the entry on the result ports is the final one
  } status_t;

endpackage

>>> sv/top_k_frequent_stream_core.sv
// Top level of the top-k frequent stream core.
// Joins tkf_ctrl and tkf_datapath; depends on tkf_pkg.
//
// The block counts the values of a stream and keeps the k most frequent ones
// in a list ranked by descending count, ties broken by ascending value.
// A request is accepted on a rising edge where start is high and busy is low;
// in_value carries the value. Values at or above VALUE_RANGE are not counted
// and leave the list untouched, but the list is still reported.
// After each request the whole list goes out on out_ranked_value, one entry
// per cycle with out_strobe high, and out_last marks the final entry. An empty
// list is reported as a single entry of value zero with out_last set.
// The first result follows the count read, count write-back, rank compare and
// list update states. A request keeps the block busy through those states and
// while the L entries of its list go out, L being the reported list length (1
// to K_MAX); busy drops after the last entry.
// The count table is a single-port-read, single-port-write memory; the rank
// compare is done across all list cells at once.
// After reset the block sweeps the count table to zero, one entry a cycle, with
// busy high. The cfg channel is always ready and sets k (top_count); it should
// be written only while the block is idle.
// The receiver cannot stall: each result is valid for exactly one cycle.
module top_k_frequent_stream_core #(
  parameter int VALUE_RANGE = 1024,
  parameter int K_MAX       = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [tkf_pkg::VALUE_BITS-1:0]    in_value,
  output logic                              out_strobe,
  output logic [tkf_pkg::VALUE_BITS-1:0]    out_ranked_value,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tkf_pkg::CFG_BITS-1:0]      cfg_top_count
);
  import tkf_pkg::*;

  // Commands flow from the controller; status flows back from the datapath.
  cmd_t    cmd;
  status_t status;

  tkf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .status     (status)
  );

  tkf_datapath #(
    .VALUE_RANGE (VALUE_RANGE),
    .K_MAX       (K_MAX),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_value         (in_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_top_count    (cfg_top_count),
    .out_ranked_value (out_ranked_value),
    .out_last         (out_last)
  );

endmodule

>>> sv/tkf_ctrl.sv
// Controller state machine of the top-k frequent stream core.
// Sequences clearing, counting, ranking and reporting; depends on tkf_pkg.
module tkf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_strobe,
  output tkf_pkg::cmd_t    cmd,
  input  tkf_pkg::status_t status
);
  import tkf_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_BUMP   = 3'd3;
  localparam logic [2:0] ST_RANK   = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_BUMP;
      end
      ST_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = ST_RANK;
      end
      ST_RANK: begin
        cmd.rank  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (status.emit_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_EMIT);

endmodule

>>> sv/tkf_datapath.sv
// Datapath of the top-k frequent stream core: count table memory, ranked list
// cells, rank compare array and result selection; depends on tkf_pkg.
module tkf_datapath #(
  parameter int VALUE_RANGE = 1024,
  parameter int K_MAX       = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tkf_pkg::cmd_t                     cmd,
  output tkf_pkg::status_t                  status,
  input  logic [tkf_pkg::VALUE_BITS-1:0]    in_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tkf_pkg::CFG_BITS-1:0]      cfg_top_count,
  output logic [tkf_pkg::VALUE_BITS-1:0]    out_ranked_value,
  output logic                              out_last
);
  import tkf_pkg::*;

  localparam int AW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int LW = $clog2(K_MAX + 1);
  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam logic [AW-1:0]         CLR_LAST  = AW'(VALUE_RANGE - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LW-1:0]         K_MAX_L   = LW'(K_MAX);

  // Count table, one read and one write port.
  logic [COUNT_BITS-1:0] mem [VALUE_RANGE];
  logic [AW-1:0]         clr_addr_r;
  logic [AW-1:0]         addr;
  logic [COUNT_BITS-1:0] rd_r;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic [COUNT_BITS-1:0] cnt_new_r;

  // Captured request.
  logic [VALUE_BITS-1:0] value_r;
  logic                  in_range_r;

  // Ranked list cells and the count that goes with each entry.
  logic [VALUE_BITS-1:0] list_val_r [K_MAX];
  logic [COUNT_BITS-1:0] list_cnt_r [K_MAX];
  logic [VALUE_BITS-1:0] list_val_nxt [K_MAX];
  logic [COUNT_BITS-1:0] list_cnt_nxt [K_MAX];
  logic [VALUE_BITS-1:0] rem_val [K_MAX];
  logic [COUNT_BITS-1:0] rem_cnt [K_MAX];
  logic [LW-1:0]         len_r;
  logic [LW-1:0]         len_nxt;
  logic [IW-1:0]         emit_idx_r;

  // Rank compare results.
  logic [K_MAX-1:0] hit_nxt;
  logic [K_MAX-1:0] ahead;
  logic [K_MAX-1:0] hit_r;
  logic [K_MAX-1:0] gone;
  logic [LW-1:0]    pos_nxt;
  logic [LW-1:0]    pos_r;
  logic             found_r;

  logic [CFG_BITS-1:0] top_count_r;
  logic [LW-1:0]       k_eff;
  logic [LW-1:0]       len_rem;
  logic [LW-1:0]       len_base;
  logic [LW-1:0]       len_pre;
  logic                ins;

  assign addr      = AW'(value_r);
  assign cnt_sat   = (rd_r == COUNT_MAX) ? rd_r : rd_r + 1'b1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.bump && in_range_r) begin
      mem[addr] <= cnt_sat;
    end
    if (cmd.read) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      top_count_r <= TOP_COUNT_RESET;
      len_r       <= '0;
      emit_idx_r  <= '0;
    end else begin
      if (cmd.clr && !status.clr_done) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_valid) top_count_r <= cfg_top_count;
      if (cmd.update && in_range_r) len_r <= len_nxt;
      if (cmd.update) begin
        emit_idx_r <= '0;
      end else if (cmd.emit_step) begin
        emit_idx_r <= emit_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r    <= in_value;
      in_range_r <= (32'(in_value) < VALUE_RANGE);
    end
    if (cmd.bump) cnt_new_r <= cnt_sat;
    if (cmd.rank) begin
      hit_r   <= hit_nxt;
      pos_r   <= pos_nxt;
      found_r <= |hit_nxt;
    end
    if (cmd.update && in_range_r) begin
      for (int i = 0; i < K_MAX; i++) begin
        list_val_r[i] <= list_val_nxt[i];
        list_cnt_r[i] <= list_cnt_nxt[i];
      end
    end
  end

  always_comb begin
    if (top_count_r == '0) begin
      k_eff = LW'(1);
    end else if (32'(top_count_r) > K_MAX) begin
      k_eff = K_MAX_L;
    end else begin
      k_eff = LW'(top_count_r);
    end
  end

  // Each valid entry is compared on its own: does it match the value, and
  // does it stay ahead of the value with its new count.
  always_comb begin
    logic valid;
    logic goes_first;
    for (int i = 0; i < K_MAX; i++) begin
      valid      = (i < int'(len_r));
      hit_nxt[i] = valid && (list_val_r[i] == value_r);
      goes_first = (cnt_new_r > list_cnt_r[i]) ||
                   ((cnt_new_r == list_cnt_r[i]) && (value_r < list_val_r[i]));
      ahead[i]   = valid && !hit_nxt[i] && !goes_first;
    end
    pos_nxt = LW'($countones(ahead));
  end

  // Close the gap left by the old copy of the value, then open a slot at its
  // rank and cut the list back to k.
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < K_MAX; i++) begin
      acc     = acc | hit_r[i];
      gone[i] = acc;
      rem_val[i] = gone[i] ? list_val_r[(i + 1 < K_MAX) ? i + 1 : i] : list_val_r[i];
      rem_cnt[i] = gone[i] ? list_cnt_r[(i + 1 < K_MAX) ? i + 1 : i] : list_cnt_r[i];
    end

    len_rem  = len_r - LW'(found_r);
    ins      = (pos_r < len_rem) || (len_rem < k_eff);
    len_base = (len_rem >= K_MAX_L) ? K_MAX_L - 1'b1 : len_rem;

    for (int i = 0; i < K_MAX; i++) begin
      if (!ins || (i < int'(pos_r))) begin
        list_val_nxt[i] = rem_val[i];
        list_cnt_nxt[i] = rem_cnt[i];
      end else if (i == int'(pos_r)) begin
        list_val_nxt[i] = value_r;
        list_cnt_nxt[i] = cnt_new_r;
      end else begin
        list_val_nxt[i] = rem_val[(i > 0) ? i - 1 : 0];
        list_cnt_nxt[i] = rem_cnt[(i > 0) ? i - 1 : 0];
      end
    end

    len_pre = ins ? len_base + 1'b1 : len_rem;
    len_nxt = (len_pre > k_eff) ? k_eff : len_pre;
  end

  assign out_ranked_value = (len_r == '0) ? '0 : list_val_r[emit_idx_r];
  assign out_last         = (len_r == '0) || ((LW'(emit_idx_r) + LW'(1)) == len_r);

  assign status.clr_done  = (clr_addr_r == CLR_LAST);
  assign status.emit_last = out_last;

endmodule

>>> sv/tkf_checker.sv
// Port-level checker for the top-k frequent stream core and its bind.
// Observes the top level's handshake ports only; no package needed.
module tkf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_last
);

  // Results only go out while a request is being worked on.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while not busy");

  // An accepted request makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted request");

  // A reported list is sent without gaps until its last entry.
  a_list_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("gap inside a reported list");

  // The block is free again right after the last entry.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> (!busy && !out_strobe))
    else $error("block still busy after the last entry");

endmodule

bind top_k_frequent_stream_core tkf_checker u_tkf_checker (.*);

>>> tb/sv/tb_top_k_frequent_stream_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for top_k_frequent_stream_core, the top-k frequent value tracker.
// Depends on tkf_pkg and the core. It predicts every ranked list in the testbench itself.
module tb_top_k_frequent_stream_core;
  import tkf_pkg::*;

  // These match the core's defaults. The predictor is sized from them too.
  localparam int VALUE_RANGE = 1024;
  localparam int K_MAX       = 16;
  localparam int COUNT_BITS  = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // The settle wait gives up after this many cycles. It must outlast the table
  // clear that follows reset.
  localparam int SETTLE_LIMIT = 4096;

  // One reported list entry, as the predictor expects to see it.
  typedef struct packed {
    logic [VALUE_BITS-1:0] ranked_value;
    logic                  last;
  } rank_entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_strobe;
  logic [VALUE_BITS-1:0] out_ranked_value;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_BITS-1:0]   cfg_top_count;

  // The predictor keeps its own copy of the block's state.
  logic [COUNT_BITS-1:0] tally [VALUE_RANGE];
  logic [VALUE_BITS-1:0] leaders [K_MAX];
  int                    leader_len;
  logic [CFG_BITS-1:0]   k_setting;

  // The list entries that are still owed by the block, oldest first.
  rank_entry_t expected_ranks[$];

  bit idle_enabled;
  int failures;
  int requests_sent;
  int results_checked;
  int k_writes;

  top_k_frequent_stream_core #(
    .VALUE_RANGE(VALUE_RANGE),
    .K_MAX(K_MAX),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_strobe(out_strobe),
    .out_ranked_value(out_ranked_value),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_top_count(cfg_top_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // This is the k in use. A setting of zero counts as one, and a setting above
  // K_MAX counts as K_MAX.
  function automatic int effective_k();
    if (k_setting == 0) return 1;
    if (k_setting > K_MAX) return K_MAX;
    return int'(k_setting);
  endfunction

  // This tells whether value a ranks ahead of value b. The higher count goes
  // first. On equal counts the lower value goes first.
  function automatic bit outranks(input logic [VALUE_BITS-1:0] a,
                                  input logic [VALUE_BITS-1:0] b);
    if (tally[a] != tally[b]) return tally[a] > tally[b];
    return a < b;
  endfunction

  function automatic void clear_prediction();
    foreach (tally[i]) tally[i] = '0;
    foreach (leaders[i]) leaders[i] = '0;
    leader_len = 0;
    k_setting  = TOP_COUNT_RESET;
  endfunction

  // This counts one value and updates the ranked list. It then queues the list
  // that the block must report for this request.
  function automatic void count_and_rank(input logic [VALUE_BITS-1:0] v);
    int          keep;
    int          n;
    int          pos;
    rank_entry_t entry;
    keep = effective_k();
    if (int'(v) < VALUE_RANGE) begin
      if (tally[v] != COUNT_MAX) tally[v] = tally[v] + 1'b1;
      // The value is pulled out of the list, and the list is closed up.
      n = 0;
      for (int i = 0; i < leader_len; i++) begin
        if (leaders[i] != v) begin
          leaders[n] = leaders[i];
          n++;
        end
      end
      leader_len = n;
      // The value goes in ahead of the first entry that it outranks.
      pos = leader_len;
      for (int i = 0; i < leader_len; i++) begin
        if (pos == leader_len && outranks(v, leaders[i])) pos = i;
      end
      // A full list that the value would only join at the end stays as it is.
      if (pos < leader_len || leader_len < keep) begin
        if (leader_len >= K_MAX) leader_len = K_MAX - 1;
        for (int i = leader_len; i > pos; i--) leaders[i] = leaders[i-1];
        leaders[pos] = v;
        leader_len++;
      end
      // A lowered k cuts the list here, after the value has been placed.
      if (leader_len > keep) leader_len = keep;
    end
    if (leader_len == 0) begin
      entry.ranked_value = '0;
      entry.last         = 1'b1;
      expected_ranks = {expected_ranks, entry};
    end else begin
      for (int i = 0; i < leader_len; i++) begin
        entry.ranked_value = leaders[i];
        entry.last         = (i == leader_len - 1);
        expected_ranks = {expected_ranks, entry};
      end
    end
  endfunction

  // The block cannot stall its results. Each strobe is therefore checked at the
  // edge that ends its cycle, against the oldest entry that is still owed.
  always @(posedge clk) begin : check_results
    rank_entry_t want;
    if (rst_n && out_strobe) begin
      results_checked++;
      if (expected_ranks.size() == 0) begin
        failures++;
        $error("unexpected result: ranked_value=%0d last=%0b",
               out_ranked_value, out_last);
      end else begin
        want = expected_ranks.pop_front();
        if (out_ranked_value !== want.ranked_value) begin
          failures++;
          $error("ranked_value mismatch: expected %0d, actual %0d",
                 want.ranked_value, out_ranked_value);
        end
        if (out_last !== want.last) begin
          failures++;
          $error("last mismatch: expected %0b, actual %0b", want.last, out_last);
        end
      end
    end
  end

  // This sends one request, with a random gap in front of it when idling is on.
  // The gap runs from the edge where the last request was accepted. A gap can
  // therefore end at any point of the block's work, or after it.
  // Start stays high when no gap follows, so requests can go back to back.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = 0;
    if (idle_enabled && $urandom_range(99) < 27) gap = $urandom_range(30, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    count_and_rank(v);
    requests_sent++;
  endtask

  // This drops start and waits until every owed result has come and the block
  // is idle. A few spare cycles follow. The wait is bounded, so a hung block
  // ends up reported as leftover results.
  task automatic settle();
    int waited;
    start  <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((expected_ranks.size() != 0 || busy) && waited < SETTLE_LIMIT);
    repeat (8) @(posedge clk);
  endtask

  // The block is brought to idle first. The new k is then written, and the
  // predictor takes the new k as well.
  task automatic write_top_count(input logic [CFG_BITS-1:0] k);
    settle();
    cfg_valid     <= 1'b1;
    cfg_top_count <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    k_setting = k;
    k_writes++;
  endtask

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
  endtask

  // These requests run at the reset value of k, which is one. The first request
  // sees a count table that reset has just cleared.
  task automatic test_reset_k();
    send_value(10'd5);
    send_value(10'd5);
    send_value(10'd1023);
    send_value(10'd0);
  endtask

  // A setting of zero must act as a k of one.
  task automatic test_k_zero();
    write_top_count(5'd0);
    send_value(10'd0);
    send_value(10'd1023);
  endtask

  // The largest setting acts as K_MAX. Fresh values fill the list. After that,
  // a value that would rank last is counted but not entered, and a value that
  // climbs to the top pushes the last entry out.
  task automatic test_full_list();
    write_top_count(5'd31);
    send_value(10'h155);
    send_value(10'h2AA);
    for (int i = 0; i < 13; i++) send_value(10'(100 + 7 * i));
    send_value(10'd1022);
    send_value(10'd5);
  endtask

  // If k drops below the list length, the list is cut at the next request. A
  // setting just above K_MAX must act as K_MAX.
  task automatic test_k_lowered();
    write_top_count(5'd3);
    send_value(10'h2AA);
    write_top_count(5'd17);
    send_value(10'd1023);
  endtask

  // This test sends random streams, in phases with different k. Most values come
  // from a small pool of hot values, so that counts climb, ranks trade places
  // and entries fall out of the list. The rest are uniform over the whole range.
  // Idling is off for one whole phase.
  task automatic test_random_stream();
    logic [VALUE_BITS-1:0] hot [24];
    logic [CFG_BITS-1:0]   phase_k [8];
    foreach (hot[i]) hot[i] = VALUE_BITS'($urandom_range(VALUE_RANGE - 1));
    phase_k[0] = 5'd16;
    phase_k[1] = 5'd1;
    phase_k[2] = 5'd31;
    phase_k[3] = 5'd8;
    phase_k[4] = 5'd0;
    phase_k[5] = 5'($urandom_range(31));
    phase_k[6] = 5'd16;
    phase_k[7] = 5'd2;
    for (int p = 0; p < 8; p++) begin
      write_top_count(phase_k[p]);
      idle_enabled = (p != 3);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(99) < 70) send_value(hot[$urandom_range(23)]);
        else send_value(VALUE_BITS'($urandom_range(VALUE_RANGE - 1)));
      end
    end
    idle_enabled = 1'b1;
  endtask

  initial begin
    start         <= 1'b0;
    in_value      <= '0;
    cfg_valid     <= 1'b0;
    cfg_top_count <= '0;
    rst_n         <= 1'b0;
    idle_enabled  = 1'b1;
    failures      = 0;
    requests_sent = 0;
    results_checked = 0;
    k_writes      = 0;
    clear_prediction();

    apply_reset();
    // After reset the block clears its count table and stays busy while it does.
    // The first request simply waits for that clear to finish.
    test_reset_k();
    test_k_zero();
    test_full_list();
    test_k_lowered();
    test_random_stream();

    settle();
    if (expected_ranks.size() != 0) begin
      failures++;
      $error("%0d expected list entries never arrived", expected_ranks.size());
    end
    $display("Sent %0d requests and checked %0d list entries over %0d writes of k.",
             requests_sent, results_checked, k_writes);
    $display("The k values included 0, 1, 16 and above 16, with lists cut and refilled.");
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The hard stop comes at 2 ms, well beyond what the run needs even with full
  // lists and the longest gaps on every request.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
